// ===== rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

   // Widths of the request and response words.
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // Request operations; the two remaining codes are treated as no operation.
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_BACK  = 3'd5
   } mode_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } ctrl_state_type;

endpackage

`default_nettype wire

// ===== rtl/deq_req_if.sv =====
`default_nettype none

// Request channel: one word holds an operation and a data word to push.
interface deq_req_if;
   logic                          valid;
   logic                          ready;
   logic [deq_pkg::MODE_W-1:0]    mode;
   logic [deq_pkg::VALUE_W-1:0]   push_value;

   modport source (output valid, output mode, output push_value, input ready);
   modport sink   (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_rsp_if.sv =====
`default_nettype none

// Response channel: one word per request.
interface deq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [deq_pkg::VALUE_W-1:0]   read_value;
   logic [deq_pkg::STATUS_W-1:0]  status;
   logic                          is_empty;
   logic [deq_pkg::FILL_W-1:0]    fill_count;

   modport source (output valid, output read_value, output status, output is_empty,
                   output fill_count, input ready);
   modport sink   (input valid, input read_value, input status, input is_empty,
                   input fill_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_store.sv =====
`default_nettype none

// Ring store: one write port and one read port with registered read data.
module deq_store #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire [DATA_WIDTH-1:0]         wr_data,
   input  wire                          rd_en,
   input  wire [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data is registered and available in the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
`default_nettype none

// Queue controller: front pointer, entry count, store addressing and the
// response register.
module deq_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   deq_req_if.sink                      req_bus,
   deq_rsp_if.source                    rsp_bus,
   output logic                         wr_en,
   output logic [$clog2(DEPTH)-1:0]     wr_addr,
   output logic [DATA_WIDTH-1:0]        wr_data,
   output logic                         rd_en,
   output logic [$clog2(DEPTH)-1:0]     rd_addr,
   input  wire  [DATA_WIDTH-1:0]        rd_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUM_W = CW + 1;
   localparam logic [AW-1:0]    LAST_POS = AW'(DEPTH - 1);
   localparam logic [CW-1:0]    FULL_CNT = CW'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

   deq_pkg::ctrl_state_type state_ff, state_in;
   logic [AW-1:0]                  front_ff, front_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [deq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                           rsp_empty_ff, rsp_empty_in;
   logic [deq_pkg::FILL_W-1:0]     rsp_fill_ff, rsp_fill_in;

   logic              accept;
   logic              is_full;
   logic              is_none;
   logic [AW-1:0]     front_dec;
   logic [AW-1:0]     front_inc;
   logic [SUM_W-1:0]  tail_sum;
   logic [AW-1:0]     tail_pos;
   logic [AW-1:0]     back_pos;

   // A new request is taken when idle and the response slot is free or draining.
   assign req_bus.ready = (state_ff == deq_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign is_full = (count_ff == FULL_CNT);
   assign is_none = (count_ff == '0);

   // Ring positions around the front pointer, wrapped modulo the depth.
   assign front_dec = (front_ff == '0) ? LAST_POS : front_ff - AW'(1);
   assign front_inc = (front_ff == LAST_POS) ? '0 : front_ff + AW'(1);
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_pos  = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
   assign back_pos  = (tail_pos == '0) ? LAST_POS : tail_pos - AW'(1);

   assign wr_data = DATA_WIDTH'(req_bus.push_value);

   // Next state, pointer updates, store accesses and the response word.
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_fill_in   = rsp_fill_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;

      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_status_in = deq_pkg::STATUS_OK;
               rsp_valid_in  = 1'b1;
               case (req_bus.mode)
                  deq_pkg::MODE_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::MODE_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_pos;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::MODE_POP_FRONT,
                  deq_pkg::MODE_PEEK_FRONT: begin
                     if (is_none) begin
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = front_ff;
                        rsp_valid_in = 1'b0;
                        state_in     = deq_pkg::ST_READ;
                        if (req_bus.mode == deq_pkg::MODE_POP_FRONT) begin
                           front_in = front_inc;
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  deq_pkg::MODE_POP_BACK,
                  deq_pkg::MODE_PEEK_BACK: begin
                     if (is_none) begin
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = back_pos;
                        rsp_valid_in = 1'b0;
                        state_in     = deq_pkg::ST_READ;
                        if (req_bus.mode == deq_pkg::MODE_POP_BACK) begin
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = deq_pkg::STATUS_OK;
                  end
               endcase
               rsp_empty_in = (count_in == '0);
               rsp_fill_in  = deq_pkg::FILL_W'(count_in);
            end
         end
         deq_pkg::ST_READ: begin
            // The store word arrives now; complete the response.
            rsp_value_in = deq_pkg::VALUE_W'(rd_data);
            rsp_valid_in = 1'b1;
            state_in     = deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_value_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.is_empty   = rsp_empty_ff;
   assign rsp_bus.fill_count = rsp_fill_ff;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
// A push, a no-op or a rejected request has its response registered in the cycle after
// acceptance; a pop or peek registers the store read, then the response word from it.
// Throughput: one push per cycle while responses are taken; pops and peeks stall input.
// Reset (synchronous) clears the front pointer, the count and the response slot;
// the store contents are not cleared, and no clearing pass is run.
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire          clock,
   input  wire          reset,
   deq_req_if.sink      req_bus,
   deq_rsp_if.source    rsp_bus
);

   localparam int AW = $clog2(DEPTH);

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // Pointer and response control.
   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Ring store holding the queued words.
   deq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
